// ----- sv/reflector_peak_detector_assert.svh -----
// Assertion macros for the reflector peak detector.
// Needs a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef REFLECTOR_PEAK_DETECTOR_ASSERT_SVH
`define REFLECTOR_PEAK_DETECTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rpd_pkg.sv -----
// Shared types and constants of the reflector peak detector.
// No dependencies.
package rpd_pkg;

    localparam int MAX_WINDOW = 32;
    localparam int MAX_BEAMS  = 4096;
    localparam int RING_DEPTH = 2 * MAX_WINDOW + 3;
    localparam int RING_AW    = 7;
    localparam int IDX_W      = 12;

    localparam logic [2:0] CFG_PEAK_THR  = 3'd0;
    localparam logic [2:0] CFG_VALLEY    = 3'd1;
    localparam logic [2:0] CFG_WINDOW    = 3'd2;
    localparam logic [2:0] CFG_MAX_DET   = 3'd3;
    localparam logic [2:0] CFG_SENS_MIN  = 3'd4;
    localparam logic [2:0] CFG_SENS_MAX  = 3'd5;

    typedef struct packed {
        logic        last;
        logic        finite;
        logic [15:0] range_mm;
        logic [15:0] intensity;
    } t_beam;

    typedef struct packed {
        logic [15:0] peak_thr;
        logic [15:0] valley_thr;
        logic [5:0]  window;
        logic [15:0] max_det;
        logic [15:0] sens_min;
        logic [15:0] sens_max;
    } t_cfg;

    typedef struct packed {
        logic  valid;
        t_beam beam;
    } t_q_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DECIDE,
        ST_DET,
        ST_SUM
    } t_state;

endpackage

// ----- sv/rpd_queue.sv -----
// Two-entry beam queue between the stream front end and the detection engine.
// Depends on rpd_pkg.
module rpd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rpd_pkg::t_beam i_beam,
    output logic           o_full,
    input  logic           i_pop,
    output rpd_pkg::t_q_out o_q
);

    rpd_pkg::t_beam r_slot [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_beam;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_full     = r_cnt == 2'd2;
    assign o_q.valid  = r_cnt != 2'd0;
    assign o_q.beam   = r_slot[r_rd];

endmodule

// ----- sv/rpd_engine.sv -----
// Detection engine: beam ring memory, window walk, decision and result register.
// Depends on rpd_pkg.
module rpd_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rpd_pkg::t_cfg   i_cfg,
    input  rpd_pkg::t_q_out i_q,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [55:0]     o_data,
    output logic            o_user
);

    rpd_pkg::t_state r_state, n_state;

    logic [32:0] r_ring [rpd_pkg::RING_DEPTH];
    logic [32:0] r_rd;
    logic [rpd_pkg::RING_AW-1:0] r_wp, wp_next, rd_addr;

    logic [11:0] r_cnt, r_nci, r_i;
    logic [7:0]  r_found;
    logic [5:0]  r_w, w_eff;
    logic        r_elig, r_last, r_pf, r_fail, r_dv;
    logic [6:0]  r_k, r_dk, back, two_w;
    logic [15:0] r_pi, r_pr, r_vl, r_vr;
    logic        r_ov, r_ouser;
    logic [55:0] r_odata;

    logic        sat, elig, ok, out_free, load_out, issue;
    logic [55:0] out_data;
    logic        out_user;
    logic [7:0]  pos_wide;
    logic [15:0] a;

    always_comb begin
        if (i_cfg.window == 6'd0) begin
            w_eff = 6'd1;
        end else if (i_cfg.window > 6'(rpd_pkg::MAX_WINDOW)) begin
            w_eff = 6'(rpd_pkg::MAX_WINDOW);
        end else begin
            w_eff = i_cfg.window;
        end
    end

    assign sat     = r_cnt >= 12'(rpd_pkg::MAX_BEAMS - 1);
    assign elig    = !sat && (r_cnt >= {5'd0, w_eff, 1'b0} + 12'd4);
    assign wp_next = (r_wp == 7'(rpd_pkg::RING_DEPTH - 1)) ? '0 : r_wp + 7'd1;
    assign two_w   = {r_w, 1'b0};
    assign issue   = (r_state == rpd_pkg::ST_WALK) && (r_k <= two_w);

    // Center first, then the left side outward, then the right side outward.
    always_comb begin
        if (r_k == 7'd0) begin
            back = {1'b0, r_w} + 7'd2;
        end else if (r_k <= {1'b0, r_w}) begin
            back = {1'b0, r_w} + 7'd2 + r_k;
        end else begin
            back = two_w + 7'd2 - r_k;
        end
        pos_wide = (r_wp >= back) ? {1'b0, r_wp - back}
                                  : {1'b0, r_wp} + 8'(rpd_pkg::RING_DEPTH) - {1'b0, back};
        rd_addr  = pos_wide[rpd_pkg::RING_AW-1:0];
    end

    assign ok = r_elig && !r_fail && (r_i >= r_nci) && (r_pi >= i_cfg.peak_thr) && r_pf
                && (r_pr >= i_cfg.sens_min) && (r_pr <= i_cfg.sens_max)
                && (r_pr <= i_cfg.max_det) && (r_vl < i_cfg.valley_thr)
                && (r_vr < i_cfg.valley_thr);
    assign out_free = !r_ov || i_ready;

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        load_out = 1'b0;
        out_data = '0;
        out_user = 1'b0;
        case (r_state)
            rpd_pkg::ST_IDLE: begin
                if (i_q.valid) begin
                    o_pop   = 1'b1;
                    n_state = elig ? rpd_pkg::ST_WALK : rpd_pkg::ST_DECIDE;
                end
            end
            rpd_pkg::ST_WALK: begin
                if (r_dv && (r_dk == two_w)) begin
                    n_state = rpd_pkg::ST_DECIDE;
                end
            end
            rpd_pkg::ST_DECIDE: begin
                if (ok) begin
                    n_state = rpd_pkg::ST_DET;
                end else if (r_last) begin
                    n_state = rpd_pkg::ST_SUM;
                end else begin
                    n_state = rpd_pkg::ST_IDLE;
                end
            end
            rpd_pkg::ST_DET: begin
                out_data = {3'd0, 1'b0, r_found, r_pi, r_pr, r_i};
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = r_last ? rpd_pkg::ST_SUM : rpd_pkg::ST_IDLE;
                end
            end
            rpd_pkg::ST_SUM: begin
                out_data = {3'd0, r_found == 8'd2, r_found, 44'd0};
                out_user = 1'b1;
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = rpd_pkg::ST_IDLE;
                end
            end
            default: n_state = rpd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ring[wp_next] <= {i_q.beam.finite, i_q.beam.range_mm, i_q.beam.intensity};
        end
        r_rd <= r_ring[rd_addr];
    end

    assign a = r_rd[15:0];

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_w    <= w_eff;
            r_elig <= elig;
            r_last <= i_q.beam.last;
            r_i    <= r_cnt - {6'd0, w_eff} - 12'd2;
            r_k    <= '0;
            r_fail <= 1'b0;
            r_vl   <= 16'hFFFF;
            r_vr   <= 16'hFFFF;
        end
        if (issue) begin
            r_k <= r_k + 7'd1;
        end
        r_dk <= r_k;
        if (r_dv) begin
            if (r_dk == 7'd0) begin
                r_pi <= r_rd[15:0];
                r_pr <= r_rd[31:16];
                r_pf <= r_rd[32];
            end else begin
                if (a > r_pi) begin
                    r_fail <= 1'b1;
                end
                if (r_dk <= {1'b0, r_w}) begin
                    if (a < r_vl) begin
                        r_vl <= a;
                    end
                end else if (a < r_vr) begin
                    r_vr <= a;
                end
            end
        end
        if (load_out) begin
            r_odata <= out_data;
            r_ouser <= out_user;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_cnt   <= '0;
            r_nci   <= '0;
            r_found <= '0;
            r_dv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_dv <= issue;
            if (o_pop) begin
                r_wp <= wp_next;
                if (!sat) begin
                    r_cnt <= r_cnt + 12'd1;
                end
            end
            if ((r_state == rpd_pkg::ST_DECIDE) && ok) begin
                if (r_found != 8'hFF) begin
                    r_found <= r_found + 8'd1;
                end
                r_nci <= r_i + {6'd0, r_w} + 12'd1;
            end
            if (load_out && out_user) begin
                r_cnt   <= '0;
                r_nci   <= '0;
                r_found <= '0;
            end
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_odata;
    assign o_user  = r_ouser;

endmodule

// ----- sv/reflector_peak_detector.sv -----
// Top level of the reflector peak detector: configuration registers, beam queue
// and detection engine. Depends on rpd_pkg, rpd_queue, rpd_engine and the assert header.

// The block takes one lidar beam per transfer and reports reflector peaks of the
// scan, followed by one summary transfer after the beam marked by tlast. A beam
// that can complete a decision is taken and written to the ring memory, then the
// center and both W-beam sides are walked through the single read port of the
// ring, and then the beam is decided; a beam that yields a detection then loads
// the result register. Other beams are only taken and decided. The summary also
// loads the result register. A two-entry queue takes beams while the engine
// works, and the result register holds a finished result while the engine goes on.
`include "reflector_peak_detector_assert.svh"

module reflector_peak_detector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: beam_intensity[15:0], beam_range_mm[31:16], range_is_finite[32].
    input  logic [39:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: peak_index[11:0], peak_range_mm[27:12], peak_intensity[43:28],
    // reflector_count[51:44], pair_found[52].
    output logic [55:0] m_axis_tdata,
    // Fields from bit 0: is_summary[0].
    output logic        m_axis_tuser
);

    rpd_pkg::t_cfg   r_cfg;
    rpd_pkg::t_beam  beam;
    rpd_pkg::t_q_out q;
    logic            full, pop;

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.peak_thr   <= 16'd43;
            r_cfg.valley_thr <= 16'd29;
            r_cfg.window     <= 6'd19;
            r_cfg.max_det    <= 16'd3000;
            r_cfg.sens_min   <= 16'd150;
            r_cfg.sens_max   <= 16'd12000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rpd_pkg::CFG_PEAK_THR: r_cfg.peak_thr   <= i_cfg_data;
                rpd_pkg::CFG_VALLEY:   r_cfg.valley_thr <= i_cfg_data;
                rpd_pkg::CFG_WINDOW:   r_cfg.window     <= i_cfg_data[5:0];
                rpd_pkg::CFG_MAX_DET:  r_cfg.max_det    <= i_cfg_data;
                rpd_pkg::CFG_SENS_MIN: r_cfg.sens_min   <= i_cfg_data;
                rpd_pkg::CFG_SENS_MAX: r_cfg.sens_max   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign beam.intensity = s_axis_tdata[15:0];
    assign beam.range_mm  = s_axis_tdata[31:16];
    assign beam.finite    = s_axis_tdata[32];
    assign beam.last      = s_axis_tlast;
    assign s_axis_tready  = !full;

    rpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid && !full),
        .i_beam  (beam),
        .o_full  (full),
        .i_pop   (pop),
        .o_q     (q)
    );

    rpd_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_q     (q),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_user  (m_axis_tuser)
    );

    `RPD_ASSERT_NOW(a_sum_no_peak, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata[43:0] == 44'd0, "summary carries peak fields")
    `RPD_ASSERT_NOW(a_det_no_pair, m_axis_tvalid && !m_axis_tuser,
        !m_axis_tdata[52] && m_axis_tdata[51:44] != 8'd0, "detection has pair flag or zero count")
    `RPD_ASSERT_NOW(a_pop_needs_item, pop, q.valid, "engine popped an empty queue")
    `RPD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "result changed while stalled")

endmodule

// ----- verif/tb_reflector_peak_detector.sv -----
// Testbench for reflector_peak_detector: drives lidar scans over the beam stream,
// predicts peak detections and scan summaries, and checks every result transfer.
// Depends on rpd_pkg and the reflector_peak_detector RTL.
module tb_reflector_peak_detector;
    timeunit 1ns;
    timeprecision 1ps;

    // One beam as it travels on the slave side.
    typedef struct {
        logic [15:0] intensity;
        logic [15:0] range_mm;
        logic        finite;
        logic        last;
    } t_tb_beam;

    // One result as it travels on the master side.
    typedef struct {
        logic [11:0] index;
        logic [15:0] range_mm;
        logic [15:0] intensity;
        logic [7:0]  count;
        logic        pair;
        logic        summary;
    } t_tb_peak;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;

    reflector_peak_detector uut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Predictor state: its own copy of the configuration and the beam history.
    logic [15:0] peak_thr, valley_thr, max_det, sens_min, sens_max;
    logic [5:0]  win_reg;
    logic [15:0] hist_int [rpd_pkg::RING_DEPTH];
    logic [15:0] hist_rng [rpd_pkg::RING_DEPTH];
    logic        hist_fin [rpd_pkg::RING_DEPTH];
    int          wr_ptr, beam_cnt, next_open, found;

    t_tb_beam beams_pending[$];
    t_tb_peak peaks_expected[$];
    int    errors;
    int    cycles;
    bit    hold_off_req;
    bit    in_gap_active;
    bit    in_taken;

    function automatic int hist_at(int back);
        return (wr_ptr + rpd_pkg::RING_DEPTH - (back % rpd_pkg::RING_DEPTH))
               % rpd_pkg::RING_DEPTH;
    endfunction

    function automatic void predictor_reset();
        peak_thr = 43; valley_thr = 29; win_reg = 19;
        max_det = 3000; sens_min = 150; sens_max = 12000;
        for (int k = 0; k < rpd_pkg::RING_DEPTH; k++) begin
            hist_int[k] = '0; hist_rng[k] = '0; hist_fin[k] = 1'b0;
        end
        wr_ptr = 0; beam_cnt = 0; next_open = 0; found = 0;
    endfunction

    // Runs one accepted beam through the detector rules, queuing what results.
    function automatic void predict_beam(t_tb_beam b);
        int w, j, ci, pos;
        bit full, ok;
        logic [15:0] pk, pr, lv, rv, a, c;
        t_tb_peak r;
        w = (win_reg == 0) ? 1 : (win_reg > rpd_pkg::MAX_WINDOW ? rpd_pkg::MAX_WINDOW
                                                               : int'(win_reg));
        full = beam_cnt >= rpd_pkg::MAX_BEAMS - 1;
        j = beam_cnt;
        wr_ptr = (wr_ptr + 1) % rpd_pkg::RING_DEPTH;
        hist_int[wr_ptr] = b.intensity;
        hist_rng[wr_ptr] = b.range_mm;
        hist_fin[wr_ptr] = b.finite;
        if (!full && j >= 2 * w + 4) begin
            ci = j - w - 2;
            pos = hist_at(w + 2);
            pk = hist_int[pos];
            pr = hist_rng[pos];
            ok = ci >= next_open && pk >= peak_thr && hist_fin[pos] && pr >= sens_min
                 && pr <= sens_max && pr <= max_det;
            if (ok) begin
                lv = 16'hFFFF; rv = 16'hFFFF;
                for (int d = 1; d <= w; d++) begin
                    a = hist_int[hist_at(w + 2 + d)];
                    c = hist_int[hist_at(w + 2 - d)];
                    if (a > pk || c > pk) ok = 0;
                    if (a < lv) lv = a;
                    if (c < rv) rv = c;
                end
                if (ok && lv < valley_thr && rv < valley_thr) begin
                    if (found < 255) found++;
                    next_open = ci + w + 1;
                    r.index = ci[11:0]; r.range_mm = pr; r.intensity = pk;
                    r.count = found[7:0]; r.pair = 1'b0; r.summary = 1'b0;
                    peaks_expected.insert(peaks_expected.size(), r);
                end
            end
        end
        if (!full) beam_cnt = j + 1;
        if (b.last) begin
            r.index = '0; r.range_mm = '0; r.intensity = '0;
            r.count = found[7:0]; r.pair = (found == 2); r.summary = 1'b1;
            peaks_expected.insert(peaks_expected.size(), r);
            beam_cnt = 0; next_open = 0; found = 0;
        end
    endfunction

    // Driver: offers queued beams, with a random gap after each one while gaps are active.
    int in_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            in_gap = 0;
            in_taken = 0;
        end else if (s_axis_tvalid && !in_taken) begin
            // Hold the offered beam until it is taken.
        end else begin
            in_taken = 0;
            if (in_gap > 0) begin
                in_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (beams_pending.size() > 0) begin
                t_tb_beam b;
                b = beams_pending.pop_front();
                s_axis_tdata  <= {7'd0, b.finite, b.range_mm, b.intensity};
                s_axis_tlast  <= b.last;
                s_axis_tvalid <= 1'b1;
                in_gap = in_gap_active ? $urandom_range(0, 6) : 0;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Input monitor: a beam is predicted when its transfer completes.
    always @(posedge i_clk) begin
        t_tb_beam b;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            b.intensity = s_axis_tdata[15:0];
            b.range_mm  = s_axis_tdata[31:16];
            b.finite    = s_axis_tdata[32];
            b.last      = s_axis_tlast;
            in_taken    = 1;
            predict_beam(b);
        end
    end

    // Receiver readiness: random stalls, plus one long hold-off on request.
    int out_gap, long_hold;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            out_gap = 0;
            long_hold = 0;
        end else if (hold_off_req && long_hold == 0) begin
            hold_off_req = 0;
            long_hold = 3000;
            m_axis_tready <= 1'b0;
        end else if (long_hold > 0) begin
            long_hold--;
            m_axis_tready <= (long_hold == 0);
        end else if (out_gap > 0) begin
            out_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (m_axis_tvalid && in_gap_active) out_gap = $urandom_range(0, 6);
        end
    end

    // Output monitor: compares each result transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_tb_peak e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (peaks_expected.size() == 0) begin
                $error("unexpected result transfer, tdata=%h tuser=%b",
                       m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                e = peaks_expected.pop_front();
                if (m_axis_tdata[11:0] !== e.index) begin
                    $error("peak_index exp %0d got %0d", e.index, m_axis_tdata[11:0]);
                    errors++;
                end
                if (m_axis_tdata[27:12] !== e.range_mm) begin
                    $error("peak_range_mm exp %0d got %0d", e.range_mm, m_axis_tdata[27:12]);
                    errors++;
                end
                if (m_axis_tdata[43:28] !== e.intensity) begin
                    $error("peak_intensity exp %0d got %0d", e.intensity,
                           m_axis_tdata[43:28]);
                    errors++;
                end
                if (m_axis_tdata[51:44] !== e.count) begin
                    $error("reflector_count exp %0d got %0d", e.count, m_axis_tdata[51:44]);
                    errors++;
                end
                if (m_axis_tdata[52] !== e.pair) begin
                    $error("pair_found exp %0b got %0b", e.pair, m_axis_tdata[52]);
                    errors++;
                end
                if (m_axis_tuser !== e.summary) begin
                    $error("is_summary exp %0b got %0b", e.summary, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // Watchdog over the whole run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 900000) begin
            $display("tb_reflector_peak_detector: done, errors");
            $finish;
        end
    end

    task automatic add_beam(int inten, int rng, bit fin, bit last);
        t_tb_beam b;
        b.intensity = inten[15:0];
        b.range_mm  = rng[15:0];
        b.finite    = fin;
        b.last      = last;
        beams_pending.insert(beams_pending.size(), b);
    endtask

    // Scan of quiet floor with a few bright, narrow reflectors at random spots.
    task automatic add_scan(int len, int n_refl);
        int spot [$];
        bit hit;
        for (int k = 0; k < n_refl; k++) spot.insert(spot.size(), $urandom_range(0, len - 1));
        for (int k = 0; k < len; k++) begin
            hit = 0;
            foreach (spot[s]) if (spot[s] == k) hit = 1;
            if (hit)
                add_beam($urandom_range(200, 65535), $urandom_range(150, 3000),
                         $urandom_range(0, 15) != 0, k == len - 1);
            else if ($urandom_range(0, 19) == 0)
                add_beam($urandom, $urandom, $urandom_range(0, 1), k == len - 1);
            else
                add_beam($urandom_range(0, 28), $urandom_range(0, 12000),
                         $urandom_range(0, 1), k == len - 1);
        end
    endtask

    task automatic wait_drained();
        while (beams_pending.size() > 0 || s_axis_tvalid || peaks_expected.size() > 0)
            @(posedge i_clk);
        // Beams that end without a result may still be inside the engine.
        repeat (2 * rpd_pkg::MAX_WINDOW + 20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, int val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[15:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            rpd_pkg::CFG_PEAK_THR: peak_thr   = val[15:0];
            rpd_pkg::CFG_VALLEY:   valley_thr = val[15:0];
            rpd_pkg::CFG_WINDOW:   win_reg    = val[5:0];
            rpd_pkg::CFG_MAX_DET:  max_det    = val[15:0];
            rpd_pkg::CFG_SENS_MIN: sens_min   = val[15:0];
            default:               sens_max   = val[15:0];
        endcase
    endtask

    initial begin
        int w;
        errors = 0;
        cycles = 0;
        hold_off_req = 0;
        in_gap_active = 1;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = rpd_pkg::CFG_PEAK_THR;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        predictor_reset();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: small window, extremes of fields, a hit on the last beam,
        // a short scan, and an unfinite peak.
        write_reg(rpd_pkg::CFG_WINDOW, 1);
        add_beam(0, 0, 0, 0);
        add_beam(0, 65535, 1, 0);
        add_beam(0, 500, 1, 0);
        add_beam(65535, 500, 1, 0);
        add_beam(0, 500, 1, 0);
        add_beam(0, 0, 0, 0);
        add_beam(0, 0, 0, 0);
        add_beam(100, 1000, 1, 0);
        add_beam(0, 0, 1, 0);
        add_beam(0, 0, 0, 0);
        add_beam(0, 0, 0, 1);
        add_beam(500, 500, 1, 1);
        add_beam(0, 0, 0, 0);
        add_beam(900, 400, 0, 0);
        add_beam(0, 0, 0, 0);
        add_beam(0, 0, 0, 0);
        add_beam(65535, 65535, 1, 1);
        wait_drained();

        // Zero window acts as one; huge window clamps to the maximum.
        write_reg(rpd_pkg::CFG_WINDOW, 0);
        write_reg(rpd_pkg::CFG_SENS_MIN, 0);
        write_reg(rpd_pkg::CFG_SENS_MAX, 65535);
        write_reg(rpd_pkg::CFG_MAX_DET, 65535);
        add_scan(40, 6);
        wait_drained();
        write_reg(rpd_pkg::CFG_WINDOW, 63);
        add_scan(120, 2);
        wait_drained();

        // Random phases with varying settings; one phase with a long hold-off.
        for (int ph = 0; ph < 8; ph++) begin
            w = (ph == 3) ? 32 : $urandom_range(1, 6);
            write_reg(rpd_pkg::CFG_WINDOW, w);
            write_reg(rpd_pkg::CFG_PEAK_THR,
                      (ph == 0) ? 0 : (ph == 1 ? 65535 : $urandom_range(30, 200)));
            write_reg(rpd_pkg::CFG_VALLEY, (ph == 2) ? 65535 : (ph == 4 ? 0 : 29));
            write_reg(rpd_pkg::CFG_MAX_DET, (ph == 5) ? 0 : $urandom_range(1000, 65535));
            write_reg(rpd_pkg::CFG_SENS_MIN, $urandom_range(0, 200));
            write_reg(rpd_pkg::CFG_SENS_MAX, (ph == 6) ? 65535 : $urandom_range(2000, 12000));
            in_gap_active = (ph != 7);
            if (ph == 5) hold_off_req = 1;
            for (int s = 0; s < 4; s++)
                add_scan((ph == 3) ? $urandom_range(60, 90) : $urandom_range(3, 32),
                         $urandom_range(0, 4));
            wait_drained();
        end

        if (errors == 0) begin
            $display("tb_reflector_peak_detector: done, clean");
        end else begin
            $display("tb_reflector_peak_detector: done, errors");
        end
        $finish;
    end
endmodule
